// File: src/tsta_pkg.sv
// Shared constants and types of the tickless sleep tick accounting block.
package tsta_pkg;

  localparam int COUNTER_BITS = 16;
  localparam logic [15:0] COUNTER_LIMIT = (COUNTER_BITS < 16) ?
      16'((64'd1 << COUNTER_BITS) - 64'd1) : 16'hFFFF;
  localparam logic [15:0] CPT_RESET = 16'd16;
  localparam int UNIT_STEPS = 16;
  localparam int STEP_BITS = $clog2(UNIT_STEPS);

  localparam logic OP_PLAN = 1'b0;
  localparam logic OP_WAKE = 1'b1;

  typedef enum logic {
    UNIT_MUL,
    UNIT_DIV
  } unit_mode_t;

  typedef struct packed {
    logic       start;
    unit_mode_t mode;
  } unit_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

// File: src/tsta_if.sv
// Valid/ready channel interfaces for plan/wake items and their answers.
interface tsta_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] expected_idle_ticks;
  logic [15:0] counter_now;
  logic        reload_matched;
  logic        sleep_abort;

  modport source (
    output valid, operation, expected_idle_ticks, counter_now, reload_matched, sleep_abort,
    input  ready
  );
  modport sink (
    input  valid, operation, expected_idle_ticks, counter_now, reload_matched, sleep_abort,
    output ready
  );
endinterface

interface tsta_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic        sleep_go;
  logic [15:0] reload_value;
  logic [15:0] ticks_elapsed;

  modport source (
    output valid, result_kind, sleep_go, reload_value, ticks_elapsed,
    input  ready
  );
  modport sink (
    input  valid, result_kind, sleep_go, reload_value, ticks_elapsed,
    output ready
  );
endinterface

// File: src/tickless_sleep_tick_accounting.sv
// Top level of the tickless sleep planning and tick accounting block.
// A plan that grants sleep and a wake without reload match each pass through the 16 steps of
// the shared multiply/divide unit in the calculation state before the answer is registered;
// refused plans and matched wakes go straight to the answer state. One transaction is worked on at a
// time, and the next is accepted once the current answer sits in the output register.
module tickless_sleep_tick_accounting (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic [15:0]   cfg_wr_data,
  tsta_in_if.sink       in_ch,
  tsta_out_if.source    out_ch
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_DONE
  } state_t;

  state_t      state_r;
  logic [15:0] cpt_r;
  logic [15:0] planned_idle_r;
  logic [15:0] acc_r;
  logic        op_r;
  logic [15:0] idle_r;
  logic [15:0] cnt_r;
  logic        matched_r;
  logic        go_r;

  logic        out_valid_r;
  logic        out_kind_r;
  logic        out_go_r;
  logic [15:0] out_reload_r;
  logic [15:0] out_ticks_r;

  tsta_pkg::unit_cmd_t unit_cmd;
  tsta_pkg::unit_sts_t unit_sts;
  logic [15:0]         res_hi, res_lo;

  logic        accept;
  logic [15:0] cpt_eff;
  logic [15:0] cnt_in;
  logic        grant_in;
  logic        div_in;
  logic        out_free;

  logic [15:0] left;
  logic [32:0] rsum;
  logic [15:0] reload;
  logic [15:0] acc_sum;
  logic [15:0] half;
  logic        bump;
  logic [15:0] acc_nxt;
  logic [16:0] q_inc;
  logic [15:0] ticks_div;
  logic [15:0] ticks_match;
  logic [15:0] ticks_sel;

  tsta_unit u_unit (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (unit_cmd),
    .op_a   (cpt_eff),
    .op_b   (grant_in ? (in_ch.expected_idle_ticks - 16'd1) : cnt_in),
    .sts    (unit_sts),
    .res_hi (res_hi),
    .res_lo (res_lo)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign cpt_eff     = (cpt_r == 16'd0) ? 16'd1 : cpt_r;
  assign cnt_in      = in_ch.counter_now & tsta_pkg::COUNTER_LIMIT;
  assign grant_in    = (in_ch.operation == tsta_pkg::OP_PLAN) &&
                       (in_ch.expected_idle_ticks >= 16'd2) && !in_ch.sleep_abort;
  assign div_in      = (in_ch.operation == tsta_pkg::OP_WAKE) && !in_ch.reload_matched;
  assign out_free    = !out_valid_r || out_ch.ready;

  always_comb begin
    unit_cmd.start = accept && (grant_in || div_in);
    unit_cmd.mode  = grant_in ? tsta_pkg::UNIT_MUL : tsta_pkg::UNIT_DIV;
  end

  always_comb begin
    left        = (cnt_r > cpt_eff) ? 16'd0 : (cpt_eff - cnt_r);
    rsum        = {17'd0, left} + {1'b0, res_hi, res_lo} - 33'd1;
    reload      = (rsum > {17'd0, tsta_pkg::COUNTER_LIMIT}) ? tsta_pkg::COUNTER_LIMIT :
                  rsum[15:0];
    acc_sum     = acc_r + res_hi;
    half        = cpt_eff >> 1;
    bump        = (acc_sum >= half);
    acc_nxt     = bump ? (acc_sum - half) : acc_sum;
    q_inc       = {1'b0, res_lo} + {16'd0, bump};
    ticks_div   = q_inc[16] ? 16'hFFFF : q_inc[15:0];
    ticks_match = (planned_idle_r != 16'd0) ? (planned_idle_r - 16'd1) : 16'd0;
    ticks_sel   = matched_r ? ticks_match : ticks_div;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      cpt_r          <= tsta_pkg::CPT_RESET;
      planned_idle_r <= '0;
      acc_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cpt_r <= cfg_wr_data;
      end
      if (out_valid_r && out_ch.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r      <= in_ch.operation;
            idle_r    <= in_ch.expected_idle_ticks;
            cnt_r     <= cnt_in;
            matched_r <= in_ch.reload_matched;
            go_r      <= grant_in;
            state_r   <= (grant_in || div_in) ? S_CALC : S_DONE;
          end
        end
        S_CALC: begin
          if (unit_sts.done) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= op_r;
            if (op_r == tsta_pkg::OP_PLAN) begin
              out_go_r     <= go_r;
              out_reload_r <= go_r ? reload : 16'd0;
              out_ticks_r  <= 16'd0;
              if (go_r) begin
                planned_idle_r <= idle_r;
              end
            end else begin
              out_go_r     <= 1'b0;
              out_reload_r <= 16'd0;
              out_ticks_r  <= ticks_sel;
              if (!matched_r) begin
                acc_r <= acc_nxt;
              end
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.result_kind   = out_kind_r;
  assign out_ch.sleep_go      = out_go_r;
  assign out_ch.reload_value  = out_reload_r;
  assign out_ch.ticks_elapsed = out_ticks_r;

  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ch.ready)
    else $error("second transaction could be accepted while one is in work");

  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    unit_sts.done |-> state_r == S_CALC)
    else $error("unit finished outside the calculation state");

  a_wake_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.result_kind == tsta_pkg::OP_WAKE |->
      !out_ch.sleep_go && out_ch.reload_value == 16'd0)
    else $error("wake answer carries plan fields");

  a_plan_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.result_kind == tsta_pkg::OP_PLAN |->
      out_ch.ticks_elapsed == 16'd0)
    else $error("plan answer carries elapsed ticks");

endmodule

// File: src/tsta_unit.sv
// Shared iterative unit: shift-add multiplier and restoring divider on one adder.
module tsta_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tsta_pkg::unit_cmd_t  cmd,
  input  logic [15:0]          op_a,
  input  logic [15:0]          op_b,
  output tsta_pkg::unit_sts_t  sts,
  output logic [15:0]          res_hi,
  output logic [15:0]          res_lo
);

  tsta_pkg::unit_mode_t            mode_r;
  logic [15:0]                     operand_r;
  logic [15:0]                     hi_r, hi_nxt;
  logic [15:0]                     lo_r, lo_nxt;
  logic [tsta_pkg::STEP_BITS-1:0]  step_r;
  logic                            busy_r;
  logic                            done_r;
  logic                            last_step;

  logic [16:0] add_x, add_y;
  logic        add_sub;
  logic [17:0] add_sum;

  assign last_step = (step_r == tsta_pkg::STEP_BITS'(tsta_pkg::UNIT_STEPS - 1));

  always_comb begin
    if (mode_r == tsta_pkg::UNIT_DIV) begin
      add_x   = {hi_r, lo_r[15]};
      add_y   = ~{1'b0, operand_r};
      add_sub = 1'b1;
    end else begin
      add_x   = {1'b0, hi_r};
      add_y   = lo_r[0] ? {1'b0, operand_r} : 17'd0;
      add_sub = 1'b0;
    end
    add_sum = {1'b0, add_x} + {1'b0, add_y} + {17'd0, add_sub};
    if (mode_r == tsta_pkg::UNIT_DIV) begin
      hi_nxt = add_sum[17] ? add_sum[15:0] : add_x[15:0];
      lo_nxt = {lo_r[14:0], add_sum[17]};
    end else begin
      hi_nxt = add_sum[16:1];
      lo_nxt = {add_sum[0], lo_r[15:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        mode_r    <= cmd.mode;
        operand_r <= op_a;
        hi_r      <= '0;
        lo_r      <= op_b;
        busy_r    <= 1'b1;
        step_r    <= '0;
      end else if (busy_r) begin
        hi_r   <= hi_nxt;
        lo_r   <= lo_nxt;
        step_r <= step_r + 1'b1;
        if (last_step) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign res_hi   = hi_r;
  assign res_lo   = lo_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> busy_r && step_r == '0)
    else $error("unit did not begin after start");

  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r) && $past(last_step))
    else $error("unit done without a final step");

endmodule
